FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the synchronized-lyrics parser
// Holds the transaction structs, the result kind codes and the frame layout
// constants used by the parser datapath, the register stages and the checker.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam int unsigned HeaderLen    = 70;
	localparam logic [6:0]  HEADER_LAST  = 7'(HeaderLen - 1);
	localparam logic [6:0]  COUNT_GATE   = 7'd27;
	localparam logic [6:0]  COUNT_POS    = 7'd28;
	localparam logic [7:0]  MARK_FIRST   = 8'h08;
	localparam logic [7:0]  MARK_SECOND  = 8'h00;
	// Sum of all bias terms: 128 + 128*128 + 16384*0xAC + 134.
	localparam logic [23:0] TIME_BIAS    = 24'd2834694;

	typedef enum logic [1:0] {
		KIND_TIME = 2'd0,
		KIND_TEXT = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [22:0] time_value;
		logic [7:0]  text_length;
		logic [7:0]  text_byte;
		logic [7:0]  record_index;
		logic        last_of_record;
	} result_t;

endpackage

FILE: rtl/slr_in_reg.sv
// ----------------------------------------------------------------------------
// slr_in_reg: input register stage
// Captures one byte transaction per cycle and holds it until the parser
// consumes it; a new transaction is taken in the same cycle as the pop.
// ----------------------------------------------------------------------------
module slr_in_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,
	input  logic                    s_tuser,
	input  logic                    pop,
	output logic                    valid_s1,
	output slr_pkg::in_item_t       item_s1
);

	assign s_tready = !valid_s1 || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte   <= s_tdata;
			item_s1.frame_start <= s_tuser;
		end
	end

endmodule

FILE: rtl/slr_parse.sv
// ----------------------------------------------------------------------------
// slr_parse: frame parse state and per-byte result logic
// Walks the header and the records of a lyrics frame one byte per fire and
// produces at most one result for each byte.
// ----------------------------------------------------------------------------
module slr_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  slr_pkg::in_item_t       item,
	output logic                    res_valid,
	output slr_pkg::result_t        res
);

	typedef enum logic [2:0] {
		PH_MARK0 = 3'd0,
		PH_MARK1 = 3'd1,
		PH_TIME2 = 3'd2,
		PH_TIME3 = 3'd3,
		PH_TIME4 = 3'd4,
		PH_LEN   = 3'd5,
		PH_TEXT  = 3'd6
	} phase_t;

	logic [6:0]  hoff_q,  hoff_c,  hoff_n;
	logic        ok_q,    ok_c,    ok_n;
	logic [7:0]  rleft_q, rleft_c, rleft_n;
	logic [7:0]  crec_q,  crec_c,  crec_n;
	phase_t      phase_q, phase_c, phase_n;
	logic [23:0] tb_q,    tb_c,    tb_n;
	logic [7:0]  tleft_q, tleft_c, tleft_n;
	logic        stop_q,  stop_c,  stop_n;
	logic [7:0]  b;
	logic [23:0] raw_sum;
	logic [23:0] time_full;
	logic [7:0]  rleft_dec;

	assign b = item.data_byte;

	assign raw_sum = {2'b0, tb_c[23:16], 14'b0} + {9'b0, tb_c[7:0], 7'b0}
		+ {16'b0, tb_c[15:8]};
	assign time_full = raw_sum - slr_pkg::TIME_BIAS;
	assign rleft_dec = rleft_c - 8'd1;

	always_comb begin
		hoff_c  = item.frame_start ? 7'd0     : hoff_q;
		ok_c    = item.frame_start ? 1'b0     : ok_q;
		rleft_c = item.frame_start ? 8'd0     : rleft_q;
		crec_c  = item.frame_start ? 8'd0     : crec_q;
		phase_c = item.frame_start ? PH_MARK0 : phase_q;
		tb_c    = item.frame_start ? 24'd0    : tb_q;
		tleft_c = item.frame_start ? 8'd0     : tleft_q;
		stop_c  = item.frame_start ? 1'b0     : stop_q;

		hoff_n  = hoff_c;
		ok_n    = ok_c;
		rleft_n = rleft_c;
		crec_n  = crec_c;
		phase_n = phase_c;
		tb_n    = tb_c;
		tleft_n = tleft_c;
		stop_n  = stop_c;

		res_valid          = 1'b0;
		res.kind           = slr_pkg::KIND_TIME;
		res.time_value     = '0;
		res.text_length    = '0;
		res.text_byte      = '0;
		res.record_index   = crec_c;
		res.last_of_record = 1'b0;

		if (!stop_c) begin
			if (hoff_c <= slr_pkg::HEADER_LAST) begin
				hoff_n = hoff_c + 7'd1;
				if (hoff_c == slr_pkg::COUNT_GATE) begin
					ok_n = (b == 8'd0);
				end else if (hoff_c == slr_pkg::COUNT_POS) begin
					rleft_n = ok_c ? b : 8'd0;
				end
				if (hoff_c == slr_pkg::HEADER_LAST && rleft_n == 8'd0) begin
					stop_n = 1'b1;
				end
			end else begin
				unique case (phase_c) inside
					PH_MARK0, PH_MARK1: begin
						if (b != ((phase_c == PH_MARK0) ? slr_pkg::MARK_FIRST
								: slr_pkg::MARK_SECOND)) begin
							res_valid = 1'b1;
							res.kind  = slr_pkg::KIND_STOP;
							stop_n    = 1'b1;
						end else begin
							phase_n = (phase_c == PH_MARK0) ? PH_MARK1 : PH_TIME2;
						end
					end
					PH_TIME2: begin
						tb_n    = {b, tb_c[15:0]};
						phase_n = PH_TIME3;
					end
					PH_TIME3: begin
						tb_n    = {tb_c[23:16], b, tb_c[7:0]};
						phase_n = PH_TIME4;
					end
					PH_TIME4: begin
						tb_n    = {tb_c[23:8], b};
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						res_valid          = 1'b1;
						res.kind           = slr_pkg::KIND_TIME;
						res.time_value     = time_full[22:0];
						res.text_length    = b;
						res.last_of_record = (b == 8'd0);
						if (b == 8'd0) begin
							crec_n  = crec_c + 8'd1;
							rleft_n = rleft_dec;
							phase_n = PH_MARK0;
							tleft_n = 8'd0;
							stop_n  = (rleft_dec == 8'd0);
						end else begin
							tleft_n = b;
							phase_n = PH_TEXT;
						end
					end
					default: begin
						res_valid          = 1'b1;
						res.kind           = slr_pkg::KIND_TEXT;
						res.text_byte      = b;
						res.last_of_record = (tleft_c <= 8'd1);
						if (tleft_c <= 8'd1) begin
							crec_n  = crec_c + 8'd1;
							rleft_n = rleft_dec;
							phase_n = PH_MARK0;
							tleft_n = 8'd0;
							stop_n  = (rleft_dec == 8'd0);
						end else begin
							tleft_n = tleft_c - 8'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hoff_q  <= 7'd0;
			ok_q    <= 1'b0;
			rleft_q <= 8'd0;
			crec_q  <= 8'd0;
			phase_q <= PH_MARK0;
			tb_q    <= 24'd0;
			tleft_q <= 8'd0;
			stop_q  <= 1'b1;
		end else if (fire) begin
			hoff_q  <= hoff_n;
			ok_q    <= ok_n;
			rleft_q <= rleft_n;
			crec_q  <= crec_n;
			phase_q <= phase_n;
			tb_q    <= tb_n;
			tleft_q <= tleft_n;
			stop_q  <= stop_n;
		end
	end

endmodule

FILE: rtl/slr_out_reg.sv
// ----------------------------------------------------------------------------
// slr_out_reg: result register stage
// Holds one result transaction for the output channel and reports when it
// can take the next one.
// ----------------------------------------------------------------------------
module slr_out_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    res_valid,
	input  slr_pkg::result_t        res,
	output logic                    free,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [47:0]             m_tdata,
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);

	slr_pkg::result_t res_q;

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tdata = {1'b0, res_q.record_index, res_q.text_byte, res_q.text_length,
		res_q.time_value};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.last_of_record;

endmodule

FILE: rtl/sync_lyrics_record_parser.sv
// ----------------------------------------------------------------------------
// sync_lyrics_record_parser: synchronized-lyrics frame record parser
// Parses a lyrics frame byte by byte and emits a timestamp result for each
// record, followed by one result per text byte; a bad record marker gives a stop.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s_*      in   tdata: data_byte[7:0]; tuser: frame_start
// m_*      out  tdata: time_value, text_length, text_byte, record_index;
//               tuser: kind; tlast: last_of_record
//
// One byte is taken every cycle while the output is not stalled; any result it
// gives passes through the input register and the result register.
// The input register, the parse logic and the result register form the path.
// Reset leaves the parser waiting for a byte with frame_start set.
// A stalled output holds the result register and, through it, the input.
// ----------------------------------------------------------------------------
module sync_lyrics_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [22:0] time_value, [30:23] text_length,
	                               // [38:31] text_byte, [46:39] record_index
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	logic              valid_s1;
	slr_pkg::in_item_t item_s1;
	logic              out_free;
	logic              pop;
	logic              res_valid;
	slr_pkg::result_t  res;

	assign pop = valid_s1 && out_free;

	slr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	slr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (pop),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	slr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pop),
		.res_valid (res_valid),
		.res       (res),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: rtl/slr_check.sv
// ----------------------------------------------------------------------------
// slr_check: port checker for the lyrics record parser
// Watches the top-level ports and flags result transactions with an undefined
// kind or fields that contradict it, and output stalls that drop or alter a result.
// ----------------------------------------------------------------------------
module slr_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("Stalled result transaction changed.");

	a_stop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == slr_pkg::KIND_STOP |-> !m_tlast && m_tdata[38:0] == 39'd0)
		else $error("Stop result carries record data.");

	a_text_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == slr_pkg::KIND_TEXT |-> m_tdata[30:0] == 31'd0)
		else $error("Text result carries time or length.");

	a_time_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == slr_pkg::KIND_TIME |-> m_tlast == (m_tdata[30:23] == 8'd0))
		else $error("Timestamp result end-of-record flag disagrees with length.");

	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == slr_pkg::KIND_TIME || m_tuser == slr_pkg::KIND_TEXT
			|| m_tuser == slr_pkg::KIND_STOP)
		else $error("Result transaction with an undefined kind.");

endmodule

bind sync_lyrics_record_parser slr_check u_slr_check (.*);

FILE: tb/sv/sync_lyrics_record_parser_tb.sv
// ----------------------------------------------------------------------------
// sync_lyrics_record_parser_tb: self-checking bench of the lyrics record parser
// Sends lyrics frames byte by byte; the bench predicts every result that the
// table does not give. A short table covers the fixed cases, and random frames
// follow. Both streams idle at random, and each result is checked field by field.
// ----------------------------------------------------------------------------
module sync_lyrics_record_parser_tb;

	import slr_pkg::*;

	localparam int          TotalItems  = 950;
	localparam int          StallLimit  = 2000;
	localparam int          DrainCycles = 8;
	localparam int          PlanLen     = 36;
	localparam logic [7:0]  TimeHiBase  = 8'hAC;
	localparam logic [7:0]  TimeLoBase  = 8'h80;
	localparam int          TimeOffset  = 134;
	localparam result_t     NO_RESULT   = '0;

	typedef enum logic [2:0] {
		PH_MARK_FIRST,
		PH_MARK_SECOND,
		PH_TIME_HI,
		PH_TIME_MID,
		PH_TIME_LO,
		PH_LENGTH,
		PH_TEXT
	} phase_t;

	typedef struct {
		bit         is_header;
		logic [7:0] data;
		logic [7:0] gate;
		bit         typed;
		result_t    want;
	} step_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
	logic        s_tuser  = 1'b0;    // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;            // [22:0] time_value, [30:23] text_length,
	                                 // [38:31] text_byte, [46:39] record_index
	logic [1:0]  m_tuser;            // [1:0] kind
	logic        m_tlast;

	// Parser state as the bench sees it.
	logic [6:0]  hdr_pos;
	logic        gate_ok;
	logic [7:0]  recs_left;
	logic [7:0]  rec_idx;
	phase_t      phase;
	logic [23:0] stamp;
	logic [7:0]  text_due;
	logic        halted;

	result_t     lyric_results_due[$];
	int          errors      = 0;
	int          sent_bytes  = 0;
	int          frames      = 0;
	int          stamps_seen = 0;
	int          texts_seen  = 0;
	int          stops_seen  = 0;
	int          idle_cycles = 0;
	int          rx_hold     = 0;
	bit          quiet_tx    = 1'b0;
	bit          rx_steady   = 1'b0;

	step_t plan [PlanLen] = '{
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'd3,  8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'hAC, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h80, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h80, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b1,
			'{KIND_TIME, 23'(-134), 8'd0, 8'h00, 8'd0, 1'b1}},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'hFF, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'hFF, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'hFF, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h02, 8'h00, 1'b1,
			'{KIND_TIME, 23'(1376121), 8'd2, 8'h00, 8'd1, 1'b0}},
		'{1'b0, 8'hFF, 8'h00, 1'b1,
			'{KIND_TEXT, 23'd0, 8'd0, 8'hFF, 8'd1, 1'b0}},
		'{1'b0, 8'h00, 8'h00, 1'b1,
			'{KIND_TEXT, 23'd0, 8'd0, 8'h00, 8'd1, 1'b1}},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h01, 8'h00, 1'b1,
			'{KIND_TIME, 23'(-2834694), 8'd1, 8'h00, 8'd2, 1'b0}},
		'{1'b0, 8'h5A, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'd2,  8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h09, 8'h00, 1'b1,
			'{KIND_STOP, 23'd0, 8'd0, 8'h00, 8'd0, 1'b0}},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'd5,  8'h40, 1'b0, NO_RESULT},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'd255, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h12, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'd2,  8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h08, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h01, 8'h00, 1'b1,
			'{KIND_STOP, 23'd0, 8'd0, 8'h00, 8'd0, 1'b0}}
	};

	sync_lyrics_record_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic void reset_parse();
		hdr_pos   = '0;
		gate_ok   = 1'b0;
		recs_left = '0;
		rec_idx   = '0;
		phase     = PH_MARK_FIRST;
		stamp     = '0;
		text_due  = '0;
	endfunction

	function automatic void close_record();
		rec_idx   = rec_idx + 8'd1;
		recs_left = recs_left - 8'd1;
		phase     = PH_MARK_FIRST;
		text_due  = '0;
		if (recs_left == 8'd0)
			halted = 1'b1;
	endfunction

	function automatic bit parse_lyric_byte(input logic [7:0] b, input logic start,
	                                        output result_t res);
		int hi;
		int mid;
		int lo;
		int t;
		res = '0;
		if (start) begin
			reset_parse();
			halted = 1'b0;
		end
		if (halted)
			return 1'b0;
		if (hdr_pos < HeaderLen) begin
			if (hdr_pos == COUNT_GATE)
				gate_ok = (b == 8'h00);
			else if (hdr_pos == COUNT_POS)
				recs_left = gate_ok ? b : 8'd0;
			hdr_pos = hdr_pos + 7'd1;
			if (hdr_pos == HeaderLen && recs_left == 8'd0)
				halted = 1'b1;
			return 1'b0;
		end
		res.record_index = rec_idx;
		case (phase)
			PH_MARK_FIRST, PH_MARK_SECOND: begin
				if (b != (phase == PH_MARK_FIRST ? MARK_FIRST : MARK_SECOND)) begin
					res.kind = KIND_STOP;
					halted   = 1'b1;
					return 1'b1;
				end
				phase = (phase == PH_MARK_FIRST) ? PH_MARK_SECOND : PH_TIME_HI;
				return 1'b0;
			end
			PH_TIME_HI: begin
				stamp = {b, 16'h0000};
				phase = PH_TIME_MID;
				return 1'b0;
			end
			PH_TIME_MID: begin
				stamp[15:8] = b;
				phase       = PH_TIME_LO;
				return 1'b0;
			end
			PH_TIME_LO: begin
				stamp[7:0] = b;
				phase      = PH_LENGTH;
				return 1'b0;
			end
			PH_LENGTH: begin
				hi  = int'(stamp[23:16]) - int'(TimeHiBase);
				mid = int'(stamp[15:8]) - int'(TimeLoBase);
				lo  = int'(stamp[7:0]) - int'(TimeLoBase);
				t   = mid + 128 * lo + 16384 * hi - TimeOffset;
				res.kind           = KIND_TIME;
				res.time_value     = t[22:0];
				res.text_length    = b;
				res.last_of_record = (b == 8'd0);
				if (b == 8'd0) begin
					close_record();
				end else begin
					text_due = b;
					phase    = PH_TEXT;
				end
				return 1'b1;
			end
			default: begin
				res.kind           = KIND_TEXT;
				res.text_byte      = b;
				res.last_of_record = (text_due <= 8'd1);
				if (text_due <= 8'd1)
					close_record();
				else
					text_due = text_due - 8'd1;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return $urandom_range(1, 2);
		if (pick < 19)
			return $urandom_range(3, 8);
		return $urandom_range(9, 40);
	endfunction

	function automatic logic [7:0] pick_time_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
	                         input result_t want);
		int      gap;
		result_t res;
		gap = (quiet_tx || $urandom_range(0, 2) != 0) ? 0 : idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
		if (start)
			frames++;
		if (parse_lyric_byte(b, start, res) && !typed)
			lyric_results_due.push_back(res);
		if (typed)
			lyric_results_due.push_back(want);
	endtask

	task automatic send_header(input logic [7:0] gate, input logic [7:0] count,
	                           input int len);
		int         i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			if (i == COUNT_GATE)
				b = gate;
			else if (i == COUNT_POS)
				b = count;
			else
				b = 8'($urandom);
			send_byte(b, i == 0, 1'b0, NO_RESULT);
		end
	endtask

	task automatic send_random_frame();
		logic [7:0] gate;
		logic [7:0] count;
		logic [7:0] len;
		logic [7:0] body[$];
		int         nrec;
		int         i;
		int         j;
		int         cut;
		gate = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		case ($urandom_range(0, 19))
			0, 1:    count = 8'd0;
			2:       count = 8'd255;
			3:       count = 8'($urandom_range(6, 20));
			default: count = 8'($urandom_range(1, 5));
		endcase
		if ($urandom_range(0, 24) == 0) begin
			send_header(gate, count, $urandom_range(1, HeaderLen - 1));
			return;
		end
		send_header(gate, count, HeaderLen);
		nrec = (count > 8'd6) ? 6 : int'(count);
		for (i = 0; i < nrec; i++) begin
			body.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom) : MARK_FIRST);
			body.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom) : MARK_SECOND);
			body.push_back(pick_time_byte());
			body.push_back(pick_time_byte());
			body.push_back(pick_time_byte());
			case ($urandom_range(0, 19))
				0, 1, 2:    len = 8'd0;
				3, 4, 5, 6: len = 8'($urandom_range(7, 30));
				7:          len = 8'($urandom_range(0, 255));
				default:    len = 8'($urandom_range(1, 6));
			endcase
			body.push_back(len);
			for (j = 0; j < int'(len); j++)
				body.push_back(8'($urandom));
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
		if ($urandom_range(0, 11) == 0 && body.size() > 1) begin
			cut = $urandom_range(1, body.size() - 1);
			while (body.size() > cut)
				void'(body.pop_back());
		end
		for (i = 0; i < body.size(); i++)
			send_byte(body[i], 1'b0, 1'b0, NO_RESULT);
	endtask

	task automatic flag_field(input string field, input logic [31:0] want,
	                          input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
				         want, got);
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
			rx_hold  <= idle_length() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind           = kind_t'(m_tuser);
			got.time_value     = m_tdata[22:0];
			got.text_length    = m_tdata[30:23];
			got.text_byte      = m_tdata[38:31];
			got.record_index   = m_tdata[46:39];
			got.last_of_record = m_tlast;
			case (got.kind)
				KIND_TIME: stamps_seen++;
				KIND_TEXT: texts_seen++;
				default:   stops_seen++;
			endcase
			if (lyric_results_due.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected result, expected none, actual %0h", $time, got);
			end else begin
				want = lyric_results_due.pop_front();
				flag_field("kind", 32'(want.kind), 32'(got.kind));
				flag_field("time_value", 32'(want.time_value), 32'(got.time_value));
				flag_field("text_length", 32'(want.text_length), 32'(got.text_length));
				flag_field("text_byte", 32'(want.text_byte), 32'(got.text_byte));
				flag_field("record_index", 32'(want.record_index), 32'(got.record_index));
				flag_field("last_of_record", 32'(want.last_of_record),
				           32'(got.last_of_record));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
			         StallLimit, lyric_results_due.size());
			$display("** sync_lyrics_record_parser: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		int directed_bytes;
		reset_parse();
		halted = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PlanLen; i++) begin
			if (plan[i].is_header)
				send_header(plan[i].gate, plan[i].data, HeaderLen);
			else
				send_byte(plan[i].data, 1'b0, plan[i].typed, plan[i].want);
		end
		directed_bytes = sent_bytes;

		while (sent_bytes < TotalItems) begin
			quiet_tx  = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 10))
					send_byte(8'($urandom), $urandom_range(0, 29) == 0, 1'b0, NO_RESULT);
			end else begin
				send_random_frame();
			end
		end
		s_tvalid <= 1'b0;

		while (lyric_results_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes in %0d frames, %0d from the directed table.", sent_bytes,
		         frames, directed_bytes);
		$display("Checked %0d timestamps, %0d text bytes and %0d stops.", stamps_seen,
		         texts_seen, stops_seen);
		if (errors == 0)
			$display("** sync_lyrics_record_parser: PASSED **");
		else
			$display("** sync_lyrics_record_parser: FAILED **");
		$finish;
	end

endmodule
